// File: hw/rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, constants and helpers for the command line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

   localparam int unsigned MAX_NESTING_DEFAULT = 16;
   localparam longint unsigned MAX_INPUT_LENGTH_DEFAULT = 65535;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_SEMI      = 8'h3B;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;

   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_STRAY  = 3'd1;
   localparam logic [2:0] ERR_ESCAPE = 3'd2;
   localparam logic [2:0] ERR_QUOTE  = 3'd3;
   localparam logic [2:0] ERR_BRACE  = 3'd4;
   localparam logic [2:0] ERR_DEEP   = 3'd5;
   localparam logic [2:0] ERR_LONG   = 3'd6;

   typedef struct packed {
      logic       mode;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [7:0]  char_out;
      logic [15:0] position;
      logic        keep_in_value;
      logic        keep_in_canonical;
      logic        separator_before;
      logic        token_done;
      logic [15:0] token_begin;
      logic [15:0] token_canon_begin;
      logic        segment_done;
      logic [15:0] segment_begin;
      logic [2:0]  error_code;
      logic [15:0] error_offset;
   } rsp_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] char_code;
      logic       is_ws;
      logic       is_quote;
      logic       is_bslash;
      logic       is_lbrace;
      logic       is_rbrace;
      logic       is_semi;
   } item_type;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

endpackage

// File: hw/rtl/command_line_tokenizer.sv
// Each transaction is stored in the queue, then the lexer registers its result.
// Throughput: one transaction per cycle unless a full output stalls the lexer.
// A four-entry queue decouples input decode from the lexer; a full output stalls the lexer.
// Reset: synchronous, active high; clears all lexer state, the queue and the output valid.
// The brace offset stack is not cleared; it is written before it is read.
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Streaming shell style command lexer with token and segment boundary reports.
// ----------------------------------------------------------------------------
module command_line_tokenizer import clt_pkg::*; #(
   parameter int unsigned     MAX_NESTING      = MAX_NESTING_DEFAULT,
   parameter longint unsigned MAX_INPUT_LENGTH = MAX_INPUT_LENGTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   item_type front_item;
   item_type queue_item;
   logic     queue_valid;
   logic     queue_ready;

   clt_front u_front (
      .req_data (req_data),
      .item     (front_item)
   );

   clt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_item)
   );

   clt_back #(
      .MAX_NESTING      (MAX_NESTING),
      .MAX_INPUT_LENGTH (MAX_INPUT_LENGTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item_ready (queue_ready),
      .item       (queue_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// File: hw/rtl/clt_front.sv
// ----------------------------------------------------------------------------
// clt_front
// Decodes each incoming transaction into character class flags.
// ----------------------------------------------------------------------------
module clt_front import clt_pkg::*; (
   input  req_type  req_data,
   output item_type item
);

   always_comb begin
      item.mode      = req_data.mode;
      item.char_code = req_data.char_code;
      item.is_ws     = (req_data.char_code == CH_SPACE) ||
                       ((req_data.char_code >= CH_TAB) && (req_data.char_code <= CH_CR));
      item.is_quote  = (req_data.char_code == CH_QUOTE);
      item.is_bslash = (req_data.char_code == CH_BACKSLASH);
      item.is_lbrace = (req_data.char_code == CH_LBRACE);
      item.is_rbrace = (req_data.char_code == CH_RBRACE);
      item.is_semi   = (req_data.char_code == CH_SEMI);
   end

endmodule

// File: hw/rtl/clt_queue.sv
// ----------------------------------------------------------------------------
// clt_queue
// Short first-in first-out queue of decoded items between front and back.
// ----------------------------------------------------------------------------
module clt_queue import clt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_data
);

   localparam int unsigned PtrWidth = $clog2(QUEUE_DEPTH);
   localparam int unsigned CntWidth = $clog2(QUEUE_DEPTH + 1);

   item_type              entry_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != CntWidth'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PtrWidth'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PtrWidth'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CntWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/clt_back.sv
// ----------------------------------------------------------------------------
// clt_back
// Lexer state machine: applies one decoded item per cycle, unless the
// held output stalls it, and registers the result transaction.
// ----------------------------------------------------------------------------
module clt_back import clt_pkg::*; #(
   parameter int unsigned      MAX_NESTING      = MAX_NESTING_DEFAULT,
   parameter longint unsigned  MAX_INPUT_LENGTH = MAX_INPUT_LENGTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     item_valid,
   output logic     item_ready,
   input  item_type item,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int unsigned DepthWidth = $clog2(MAX_NESTING + 1);
   localparam int unsigned IdxWidth   = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
   localparam logic [DepthWidth-1:0] MaxDepth = DepthWidth'(MAX_NESTING);
   localparam logic [15:0] LenLimit =
      (MAX_INPUT_LENGTH < 64'd65535) ? 16'(MAX_INPUT_LENGTH) : 16'hFFFF;

   logic                  esc_ff, esc_in;
   logic                  inq_ff, inq_in;
   logic [DepthWidth-1:0] depth_ff, depth_in;
   logic [15:0]           quote_start_ff, quote_start_in;
   logic                  tok_open_ff, tok_open_in;
   logic                  sep_pend_ff, sep_pend_in;
   logic                  seg_has_ff, seg_has_in;
   logic [15:0]           pos_ff, pos_in;
   logic [15:0]           canon_ff, canon_in;
   logic [15:0]           tok_start_ff, tok_start_in;
   logic [15:0]           tok_canon_ff, tok_canon_in;
   logic [15:0]           seg_start_ff, seg_start_in;
   logic [2:0]            err_ff, err_in;
   logic [15:0]           err_off_ff, err_off_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff, rsp_in;

   logic [15:0]           stack_mem [MAX_NESTING];
   logic [15:0]           top_ff;
   logic                  push;
   logic [DepthWidth-1:0] depth_m1;
   logic                  fire;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign fire       = item_valid && item_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign depth_m1   = depth_in - DepthWidth'(1);

   always_comb begin
      logic        do_open;
      logic        kv;
      logic        kc;
      logic        sep;
      logic        close_seg;
      logic        ws_case;
      logic        top_level;
      logic        seg_after;
      logic [15:0] canon_v;

      do_open   = 1'b0;
      kv        = 1'b0;
      kc        = 1'b0;
      sep       = 1'b0;
      close_seg = 1'b0;
      ws_case   = 1'b0;
      top_level = !inq_ff && (depth_ff == '0);
      seg_after = seg_has_ff || tok_open_ff;
      canon_v   = canon_ff;
      push      = 1'b0;

      esc_in         = esc_ff;
      inq_in         = inq_ff;
      depth_in       = depth_ff;
      quote_start_in = quote_start_ff;
      tok_open_in    = tok_open_ff;
      sep_pend_in    = sep_pend_ff;
      seg_has_in     = seg_has_ff;
      pos_in         = pos_ff;
      canon_in       = canon_ff;
      tok_start_in   = tok_start_ff;
      tok_canon_in   = tok_canon_ff;
      seg_start_in   = seg_start_ff;
      err_in         = err_ff;
      err_off_in     = err_off_ff;

      rsp_in          = '0;
      rsp_in.position = pos_ff;

      if (item.mode) begin
         if (err_ff == ERR_NONE) begin
            if (esc_ff) begin
               err_in     = ERR_ESCAPE;
               err_off_in = (pos_ff == '0) ? '0 : pos_ff - 16'd1;
            end else if (inq_ff) begin
               err_in     = ERR_QUOTE;
               err_off_in = quote_start_ff;
            end else if (depth_ff != '0) begin
               err_in     = ERR_BRACE;
               err_off_in = top_ff;
            end else begin
               if (tok_open_ff) begin
                  rsp_in.token_done        = 1'b1;
                  rsp_in.token_begin       = tok_start_ff;
                  rsp_in.token_canon_begin = tok_canon_ff;
               end
               if (seg_after) begin
                  rsp_in.segment_done  = 1'b1;
                  rsp_in.segment_begin = seg_start_ff;
               end
            end
         end
         rsp_in.error_code   = err_in;
         rsp_in.error_offset = err_off_in;
         esc_in         = 1'b0;
         inq_in         = 1'b0;
         depth_in       = '0;
         quote_start_in = '0;
         tok_open_in    = 1'b0;
         sep_pend_in    = 1'b0;
         seg_has_in     = 1'b0;
         pos_in         = '0;
         canon_in       = '0;
         tok_start_in   = '0;
         tok_canon_in   = '0;
         seg_start_in   = '0;
         err_in         = ERR_NONE;
         err_off_in     = '0;
      end else begin
         rsp_in.char_out = item.char_code;
         if (err_ff != ERR_NONE) begin
            pos_in = sat_inc(pos_ff);
         end else if (pos_ff >= LenLimit) begin
            err_in     = ERR_LONG;
            err_off_in = pos_ff;
         end else begin
            pos_in = pos_ff + 16'd1;
            if (esc_ff) begin
               do_open = 1'b1;
               kv      = 1'b1;
               kc      = 1'b1;
               esc_in  = 1'b0;
            end else if (inq_ff && item.is_bslash) begin
               do_open = 1'b1;
               kv      = 1'b1;
               kc      = 1'b1;
               esc_in  = 1'b1;
            end else if (item.is_quote) begin
               do_open = 1'b1;
               kc      = 1'b1;
               kv      = (depth_ff != '0);
               inq_in  = !inq_ff;
               if (!inq_ff) begin
                  quote_start_in = pos_ff;
               end
            end else if (!inq_ff && item.is_lbrace) begin
               if (depth_ff >= MaxDepth) begin
                  err_in     = ERR_DEEP;
                  err_off_in = pos_ff;
               end else begin
                  do_open  = 1'b1;
                  kv       = 1'b1;
                  kc       = 1'b1;
                  push     = 1'b1;
                  depth_in = depth_ff + DepthWidth'(1);
               end
            end else if (!inq_ff && item.is_rbrace) begin
               if (depth_ff == '0) begin
                  err_in     = ERR_STRAY;
                  err_off_in = pos_ff;
               end else begin
                  do_open  = 1'b1;
                  kv       = 1'b1;
                  kc       = 1'b1;
                  depth_in = depth_ff - DepthWidth'(1);
               end
            end else if (top_level && item.is_semi) begin
               close_seg = 1'b1;
            end else if (top_level && item.is_ws) begin
               ws_case = 1'b1;
            end else begin
               do_open = 1'b1;
               kv      = 1'b1;
               kc      = 1'b1;
            end

            if (do_open && !tok_open_ff) begin
               sep = sep_pend_ff && (canon_ff != '0);
               if (sep) begin
                  canon_v = sat_inc(canon_v);
               end
               sep_pend_in  = 1'b0;
               tok_open_in  = 1'b1;
               tok_start_in = pos_ff;
               tok_canon_in = canon_v;
               if (!seg_has_ff) begin
                  seg_start_in = pos_ff;
               end
            end

            if ((close_seg || ws_case) && tok_open_ff) begin
               rsp_in.token_done        = 1'b1;
               rsp_in.token_begin       = tok_start_ff;
               rsp_in.token_canon_begin = tok_canon_ff;
               tok_open_in              = 1'b0;
            end

            if (ws_case) begin
               seg_has_in  = seg_after;
               sep_pend_in = seg_after;
            end

            if (close_seg) begin
               if (seg_after) begin
                  rsp_in.segment_done  = 1'b1;
                  rsp_in.segment_begin = seg_start_ff;
                  canon_v              = '0;
               end
               seg_has_in  = 1'b0;
               sep_pend_in = 1'b0;
            end

            if (kc) begin
               canon_v = sat_inc(canon_v);
            end
            canon_in = canon_v;

            rsp_in.keep_in_value     = kv;
            rsp_in.keep_in_canonical = kc;
            rsp_in.separator_before  = sep;
         end
         rsp_in.error_code   = err_in;
         rsp_in.error_offset = err_off_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff         <= 1'b0;
         inq_ff         <= 1'b0;
         depth_ff       <= '0;
         quote_start_ff <= '0;
         tok_open_ff    <= 1'b0;
         sep_pend_ff    <= 1'b0;
         seg_has_ff     <= 1'b0;
         pos_ff         <= '0;
         canon_ff       <= '0;
         tok_start_ff   <= '0;
         tok_canon_ff   <= '0;
         seg_start_ff   <= '0;
         err_ff         <= ERR_NONE;
         err_off_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (fire) begin
            esc_ff         <= esc_in;
            inq_ff         <= inq_in;
            depth_ff       <= depth_in;
            quote_start_ff <= quote_start_in;
            tok_open_ff    <= tok_open_in;
            sep_pend_ff    <= sep_pend_in;
            seg_has_ff     <= seg_has_in;
            pos_ff         <= pos_in;
            canon_ff       <= canon_in;
            tok_start_ff   <= tok_start_in;
            tok_canon_ff   <= tok_canon_in;
            seg_start_ff   <= seg_start_in;
            err_ff         <= err_in;
            err_off_ff     <= err_off_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // The innermost open brace offset is kept in a register; it takes the new
   // offset on a push and is refilled from the stack on every other item taken.
   always_ff @(posedge clock) begin
      if (fire && push) begin
         stack_mem[depth_ff[IdxWidth-1:0]] <= pos_ff;
      end
      if (fire) begin
         top_ff <= push ? pos_ff : stack_mem[depth_m1[IdxWidth-1:0]];
      end
   end

endmodule
